>>> hw/rtl/deq_pkg.sv
// Types and codes shared by the double-ended queue modules.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;
  localparam logic [2:0] ACT_REVERSE    = 3'd5;
  localparam logic [2:0] ACT_SORT       = 3'd6;
  localparam logic [2:0] ACT_QUERY      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] WORD_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_word;
    logic signed [31:0] back_word;
    logic [7:0]         count;
    logic               is_empty;
  } deq_out_t;
endpackage
`default_nettype wire

>>> hw/rtl/deq_ram.sv
// Single-port-write, single-port-read word memory with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/double_ended_queue_top.sv
// Double-ended queue top level: control sequencer around a ring memory.
//
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | deq_in_t
//   output  | out_valid, out_stall, out_data | deq_out_t
//
// Push, pop, clear and query pass through the accepting state S_IDLE with
// any memory write, reads of the front and back words through the single
// read port (S_RDF, S_RDB), and the state S_FIN that forms the result.
// Reverse adds a pass through S_RVA, S_RVB, S_RVW and S_OUT per swapped pair;
// sort is an insertion sort through S_SKEY, S_SCMP, S_SCHK and S_SWB.
// Reset is synchronous; the memory needs no clearing. The input is stalled
// while an item is being worked, and a finished item waits while the previous
// result is held in the output register.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire deq_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output deq_out_t      out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDF   = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_FIN   = 4'd3;
  localparam logic [3:0] S_OUT   = 4'd4;
  localparam logic [3:0] S_RVA   = 4'd5;
  localparam logic [3:0] S_RVB   = 4'd6;
  localparam logic [3:0] S_RVW   = 4'd7;
  localparam logic [3:0] S_SKEY  = 4'd8;
  localparam logic [3:0] S_SCMP  = 4'd9;
  localparam logic [3:0] S_SCHK  = 4'd10;
  localparam logic [3:0] S_SWB   = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   front_r, front_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [31:0]   ta_r, ta_nxt;
  logic          out_valid_r, out_valid_nxt;
  deq_out_t      out_r, out_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, k};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  deq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    occ_nxt = occ_r;
    status_nxt = status_r;
    front_nxt = front_r;
    i_nxt = i_r;
    j_nxt = j_r;
    ta_nxt = ta_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    we = 1'b0;
    waddr = head_r;
    wdata = in_data.value;
    raddr = head_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          status_nxt = ST_OK;
          state_nxt = S_RDF;
          case (in_data.action)
            ACT_PUSH_FRONT: begin
              if (occ_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt = slot(head_r, CW'(DEPTH - 1));
                waddr = head_nxt;
                we = 1'b1;
                occ_nxt = occ_r + 1'b1;
              end
            end
            ACT_PUSH_BACK: begin
              if (occ_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                waddr = slot(head_r, occ_r);
                we = 1'b1;
                occ_nxt = occ_r + 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt = slot(head_r, CW'(1));
                occ_nxt = occ_r - 1'b1;
              end
            end
            ACT_POP_BACK: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                occ_nxt = occ_r - 1'b1;
              end
            end
            ACT_CLEAR: begin
              head_nxt = '0;
              occ_nxt = '0;
            end
            ACT_REVERSE: begin
              if (occ_r > CW'(1)) begin
                i_nxt = '0;
                j_nxt = occ_r - 1'b1;
                state_nxt = S_RVA;
              end
            end
            ACT_SORT: begin
              if (occ_r > CW'(1)) begin
                i_nxt = CW'(1);
                state_nxt = S_SKEY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDF: begin
        raddr = head_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        raddr = slot(head_r, occ_r - 1'b1);
        front_nxt = rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        raddr = slot(head_r, occ_r - 1'b1);
        if (!out_valid_r || !out_stall) begin
          out_nxt.status = status_r;
          out_nxt.count = 8'(occ_r);
          out_nxt.is_empty = (occ_r == '0);
          out_nxt.front_word = (occ_r == '0) ? WORD_NONE : front_r;
          out_nxt.back_word = (occ_r == '0) ? WORD_NONE : rdata;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RVA: begin
        if (i_r >= j_r) begin
          state_nxt = S_RDF;
        end else begin
          raddr = slot(head_r, i_r);
          state_nxt = S_RVB;
        end
      end
      S_RVB: begin
        raddr = slot(head_r, j_r);
        ta_nxt = rdata;
        state_nxt = S_RVW;
      end
      S_RVW: begin
        we = 1'b1;
        waddr = slot(head_r, i_r);
        wdata = rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        we = 1'b1;
        waddr = slot(head_r, j_r);
        wdata = ta_r;
        i_nxt = i_r + 1'b1;
        j_nxt = j_r - 1'b1;
        state_nxt = S_RVA;
      end
      S_SKEY: begin
        if (i_r >= occ_r) begin
          state_nxt = S_RDF;
        end else begin
          raddr = slot(head_r, i_r);
          j_nxt = i_r;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        ta_nxt = rdata;
        raddr = slot(head_r, j_r - 1'b1);
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if ($signed(ta_r) < $signed(rdata)) begin
          we = 1'b1;
          waddr = slot(head_r, j_r);
          wdata = rdata;
          j_nxt = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            state_nxt = S_SWB;
          end else begin
            raddr = slot(head_r, j_r - CW'(2));
          end
        end else begin
          state_nxt = S_SWB;
        end
      end
      S_SWB: begin
        we = 1'b1;
        waddr = slot(head_r, j_r);
        wdata = ta_r;
        i_nxt = i_r + 1'b1;
        state_nxt = S_SKEY;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      occ_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      occ_r <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    front_r <= front_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    ta_r <= ta_nxt;
    out_r <= out_nxt;
  end
endmodule
`default_nettype wire

>>> hw/rtl/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module deq_checker
  import deq_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire deq_out_t out_data
);
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.count == 8'd0)))
    else $error("Empty flag disagrees with the count.");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |->
      (out_data.front_word == WORD_NONE && out_data.back_word == WORD_NONE))
    else $error("Empty result carries words.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A second transfer was accepted while an item was in work.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("A stalled result changed.");
endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the double-ended queue top level.
`timescale 1ns / 1ps
module tb;
  import deq_pkg::*;

  localparam int DEPTH = 128;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_out_t out_data;

  double_ended_queue_top #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0] ring [DEPTH];
  int          front_pos;
  int          held;
  deq_out_t    expected_q [$];
  int          mismatches;
  int          hold_off = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  bit          hold_busy;

  function automatic int at(input int k);
    return (front_pos + k) % DEPTH;
  endfunction

  function automatic deq_out_t predict_deque(input deq_in_t it);
    deq_out_t r;
    logic [31:0] t;
    int i;
    int j;
    r.status = ST_OK;
    case (it.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else if (it.action == ACT_PUSH_FRONT) begin
          front_pos = (front_pos + DEPTH - 1) % DEPTH;
          ring[front_pos] = it.value;
          held++;
        end else begin
          ring[at(held)] = it.value;
          held++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (it.action == ACT_POP_FRONT) front_pos = at(1);
          held--;
        end
      end
      ACT_CLEAR: begin
        front_pos = 0;
        held = 0;
      end
      ACT_REVERSE: begin
        for (i = 0; i < held / 2; i++) begin
          t = ring[at(i)];
          ring[at(i)] = ring[at(held - 1 - i)];
          ring[at(held - 1 - i)] = t;
        end
      end
      ACT_SORT: begin
        for (i = 1; i < held; i++) begin
          t = ring[at(i)];
          j = i;
          while (j > 0 && $signed(t) < $signed(ring[at(j - 1)])) begin
            ring[at(j)] = ring[at(j - 1)];
            j--;
          end
          ring[at(j)] = t;
        end
      end
      default: ;
    endcase
    r.count = held[7:0];
    r.is_empty = (held == 0);
    r.front_word = (held == 0) ? WORD_NONE : ring[at(0)];
    r.back_word = (held == 0) ? WORD_NONE : ring[at(held - 1)];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A transfer happens when valid is high and stall is low at a rising edge.
  task automatic send_item(input logic [2:0] act, input logic [31:0] val, input bit gaps);
    int g;
    deq_in_t it;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(posedge clk);
    it.action = act;
    it.value = val;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, predict_deque(it)};
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    deq_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_data);
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (out_data.status !== e.status || out_data.front_word !== e.front_word ||
            out_data.back_word !== e.back_word || out_data.count !== e.count ||
            out_data.is_empty !== e.is_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected st=%0d f=%0d b=%0d n=%0d e=%0b, got st=%0d f=%0d b=%0d n=%0d e=%0b",
                     e.status, e.front_word, e.back_word, e.count, e.is_empty,
                     out_data.status, out_data.front_word, out_data.back_word,
                     out_data.count, out_data.is_empty);
        end
      end
    end
  end

  // The receiver never stalls, stalls at random or holds off for a counted stretch.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 200;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (hold_busy) begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_empty_cases();
    send_item(ACT_POP_FRONT, 32'h0, 0);
    send_item(ACT_POP_BACK, 32'h0, 0);
    send_item(ACT_REVERSE, 32'h0, 0);
    send_item(ACT_SORT, 32'h0, 0);
    send_item(ACT_QUERY, 32'h0, 0);
    send_item(ACT_CLEAR, 32'h0, 0);
  endtask

  task automatic test_directed_ops();
    send_item(ACT_PUSH_BACK, 32'h7FFF_FFFF, 0);
    send_item(ACT_PUSH_FRONT, 32'h8000_0000, 0);
    send_item(ACT_PUSH_BACK, 32'hFFFF_FFFF, 0);
    send_item(ACT_PUSH_FRONT, 32'h0, 0);
    send_item(ACT_PUSH_BACK, 32'h5555_5555, 0);
    send_item(ACT_PUSH_FRONT, 32'hAAAA_AAAA, 0);
    send_item(ACT_REVERSE, 32'h0, 0);
    send_item(ACT_SORT, 32'h0, 0);
    send_item(ACT_POP_FRONT, 32'h0, 0);
    send_item(ACT_POP_BACK, 32'h0, 0);
    send_item(ACT_QUERY, 32'h1234_5678, 0);
    send_item(ACT_CLEAR, 32'h0, 0);
    send_item(ACT_PUSH_BACK, 32'h1, 0);
    send_item(ACT_REVERSE, 32'h0, 0);
    send_item(ACT_SORT, 32'h0, 0);
  endtask

  task automatic test_full();
    int i;
    send_item(ACT_CLEAR, 32'h0, 1);
    for (i = 0; i < DEPTH; i++)
      send_item(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom, 1);
    send_item(ACT_PUSH_BACK, $urandom, 0);
    send_item(ACT_PUSH_FRONT, $urandom, 0);
    send_item(ACT_REVERSE, 32'h0, 0);
    send_item(ACT_SORT, 32'h0, 0);
    for (i = 0; i < DEPTH + 2; i++)
      send_item(i[0] ? ACT_POP_FRONT : ACT_POP_BACK, 32'h0, 1);
  endtask

  task automatic test_hold_off();
    int i;
    hold_req = hold_req + 1;
    for (i = 0; i < 10; i++) send_item(ACT_PUSH_BACK, $urandom, 0);
    wait_drained();
  endtask

  task automatic test_random();
    int n;
    int p;
    logic [2:0] act;
    for (n = 0; n < 600; n++) begin
      p = $urandom_range(0, 99);
      if (p < 30) act = ACT_PUSH_BACK;
      else if (p < 55) act = ACT_PUSH_FRONT;
      else if (p < 70) act = ACT_POP_FRONT;
      else if (p < 84) act = ACT_POP_BACK;
      else if (p < 86) act = ACT_CLEAR;
      else if (p < 91) act = ACT_REVERSE;
      else if (p < 94 && held <= 24) act = ACT_SORT;
      else act = ACT_QUERY;
      send_item(act, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) - 4 : $urandom, 1);
      if (n == 300) wait_drained();
    end
  endtask

  initial begin
    int w;
    front_pos = 0;
    held = 0;
    mismatches = 0;
    hold_busy = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_cases();
    test_directed_ops();
    hold_busy = 1;
    test_full();
    test_hold_off();
    test_random();
    wait_drained();
    w = 0;
    while (expected_q.size() == 0 && w < 100) begin
      @(posedge clk);
      w++;
    end
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS double_ended_queue_top");
    end else begin
      $display("FAIL double_ended_queue_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL double_ended_queue_top");
    $finish;
  end
endmodule
